// ===== rtl/core/lvrs_pkg.sv =====
// Package for the linear velocity reference shaper: widths, register indexes,
// sequencer states and small arithmetic helpers. No dependencies.
package lvrs_pkg;

  localparam int SPD_W     = 24;  // signed Q8.16 speeds and integral
  localparam int DT_W      = 16;  // tick length in microseconds
  localparam int LIM_W     = 23;  // unsigned limits and dead zone
  localparam int ALPHA_W   = 17;  // filter coefficient, Q0.16 plus one
  localparam int TMO_W     = 24;  // release timeout and elapsed time
  localparam int CFG_W     = 24;  // widest register
  localparam int REG_IDX_W = 3;

  localparam int MUL_A_W   = 24;  // magnitude operand
  localparam int MUL_B_W   = 17;  // serial operand, scanned one bit a cycle
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W   = 42;  // dividend width of the microsecond divider
  localparam int MS_W      = 20;  // largest step per tick fits here

  localparam int US_PER_S  = 1000000;
  localparam int HALF_S    = US_PER_S / 2;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEAD_ZONE    = 3'd0,
    REG_FILTER_ALPHA = 3'd1,
    REG_ACCEL_LIMIT  = 3'd2,
    REG_DECEL_LIMIT  = 3'd3,
    REG_REL_DECEL    = 3'd4,
    REG_REL_TIMEOUT  = 3'd5,
    REG_STOP_SPEED   = 3'd6,
    REG_INT_LIMIT    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_RMUL,
    S_RDIV,
    S_IMUL,
    S_IDIV,
    S_OUT
  } seq_state_e;

  // Magnitude of a 24-bit signed value; the most negative value fits unsigned.
  function automatic logic [SPD_W-1:0] abs24(input logic signed [SPD_W-1:0] x);
    logic signed [SPD_W:0] w;
    w = {x[SPD_W-1], x};
    if (x[SPD_W-1]) w = -w;
    return w[SPD_W-1:0];
  endfunction

  // Saturate a 27-bit signed sum to 24 bits signed.
  function automatic logic signed [SPD_W-1:0] sat24(input logic signed [26:0] x);
    if (x > 27'sd8388607) return 24'sh7FFFFF;
    if (x < -27'sd8388608) return 24'sh800000;
    return x[SPD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lvrs_intf.sv =====
// Handshake channel interfaces of the velocity reference shaper.
// Depends on lvrs_pkg for the field widths.
interface lvrs_in_if import lvrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DT_W-1:0]         step_time_us;
  logic signed [SPD_W-1:0] command_speed;
  logic signed [SPD_W-1:0] measured_speed;
  logic                    recover_mode;
  logic                    jump_mode;
  logic signed [SPD_W-1:0] jump_speed;

  modport source (output valid, step_time_us, command_speed, measured_speed,
                  recover_mode, jump_mode, jump_speed, input ready);
  modport sink (input valid, step_time_us, command_speed, measured_speed,
                recover_mode, jump_mode, jump_speed, output ready);
endinterface

interface lvrs_out_if import lvrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] reference_speed;
  logic signed [SPD_W-1:0] error_integral;
  logic                    releasing;

  modport source (output valid, reference_speed, error_integral, releasing,
                  input ready);
  modport sink (input valid, reference_speed, error_integral, releasing,
                output ready);
endinterface

// ===== rtl/core/lvrs_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on lvrs_pkg for default widths.
module lvrs_mul import lvrs_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] p_o
);
  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(B_W + 1);

  logic [P_W-1:0] acc_q, sh_q;
  logic [B_W-1:0] b_q;
  logic [C_W-1:0] cnt_q;
  logic           run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      sh_q   <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q <= '0;
        sh_q  <= P_W'(a_i);
        b_q   <= b_i;
        cnt_q <= C_W'(B_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        if (b_q[0]) acc_q <= acc_q + sh_q;
        sh_q  <= sh_q << 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== rtl/core/lvrs_div.sv =====
// Restoring divider by a constant, one quotient bit per cycle.
// Depends on lvrs_pkg for default widths and the divisor.
module lvrs_div import lvrs_pkg::*; #(
  parameter int N_W = DIV_N_W,
  parameter int D   = US_PER_S
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] n_i,
  output logic           done_o,
  output logic [N_W-1:0] q_o
);
  localparam int R_W = $clog2(D);
  localparam int C_W = $clog2(N_W + 1);

  logic [N_W-1:0] nq_q;
  logic [R_W-1:0] rem_q;
  logic [C_W-1:0] cnt_q;
  logic           run_q, done_q;
  logic [R_W:0]   trial;
  logic           ge;

  assign trial = {rem_q, nq_q[N_W-1]};
  assign ge    = trial >= (R_W+1)'(D);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q   <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        nq_q  <= n_i;
        rem_q <= '0;
        cnt_q <= C_W'(N_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? R_W'(trial - (R_W+1)'(D)) : trial[R_W-1:0];
        nq_q  <= {nq_q[N_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = nq_q;
endmodule

// ===== rtl/core/linear_velocity_reference_shaper_unit.sv =====
// Top level of the linear velocity reference shaper.
// Depends on lvrs_pkg, lvrs_intf, lvrs_mul and lvrs_div.
//
// Use: one request on in_i carries one control tick (tick length, commanded
// and measured speed, recovery and jump flags, jump speed). For each accepted
// request exactly one result leaves on out_o: the shaped reference speed,
// the clamped error integral and the release flag. Both channels move a
// request when valid and ready are high at a rising edge of clk_i.
// The eight tuning registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i, one per cycle. The user must write them only while no tick
// is in flight; the block itself does not enforce it.
// A recovery or jump tick runs the filter product only; a tick whose release
// window stays open adds the rate product and its divide by one million, and
// any other tick also adds the integral product and its divide. The bit-serial
// multiplier and divider run in turn, each result taken by the sequencer
// state that waits on it. A new tick is taken the cycle after the previous
// one has reached the output register. The result waits there while the
// receiver stalls, and a following tick may be worked on meanwhile, holding
// its own result until the register frees.
// Reset (rst_ni low, asynchronous) clears all shaper state and restores the
// register defaults; a tick in flight and a result not yet taken are dropped.
module linear_velocity_reference_shaper_unit import lvrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lvrs_in_if.sink              in_i,
  lvrs_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Tuning registers.
  logic [LIM_W-1:0]   dz_q, acc_lim_q, dec_lim_q, rdec_q, stop_q, ilim_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [TMO_W-1:0]   tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q      <= LIM_W'(1311);
      alpha_q   <= ALPHA_W'(2674);
      acc_lim_q <= LIM_W'(104858);
      dec_lim_q <= LIM_W'(203162);
      rdec_q    <= LIM_W'(471859);
      tmo_q     <= TMO_W'(450000);
      stop_q    <= LIM_W'(2294);
      ilim_q    <= LIM_W'(65536);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEAD_ZONE:    dz_q      <= cfg_wdata_i[LIM_W-1:0];
        REG_FILTER_ALPHA: alpha_q   <= cfg_wdata_i[ALPHA_W-1:0];
        REG_ACCEL_LIMIT:  acc_lim_q <= cfg_wdata_i[LIM_W-1:0];
        REG_DECEL_LIMIT:  dec_lim_q <= cfg_wdata_i[LIM_W-1:0];
        REG_REL_DECEL:    rdec_q    <= cfg_wdata_i[LIM_W-1:0];
        REG_REL_TIMEOUT:  tmo_q     <= cfg_wdata_i[TMO_W-1:0];
        REG_STOP_SPEED:   stop_q    <= cfg_wdata_i[LIM_W-1:0];
        REG_INT_LIMIT:    ilim_q    <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficients above one act as exactly one.
  logic [ALPHA_W-1:0] alpha_eff;
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

  // Shared serial arithmetic units.
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n, div_q;

  lvrs_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  lvrs_div #(.N_W(DIV_N_W), .D(US_PER_S)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n),
    .done_o(div_done), .q_o(div_q)
  );

  // Sequencer and shaper state.
  seq_state_e state_q, state_d;

  logic signed [SPD_W-1:0] filt_q, filt_d, ref_q, ref_d, int_q, int_d;
  logic signed [SPD_W-1:0] tgt_q, tgt_d, meas_q, meas_d, js_q, js_d;
  logic                    rel_q, rel_d, had_q, had_d;
  logic [TMO_W-1:0]        el_q, el_d;
  logic [DT_W-1:0]         dt_q, dt_d;
  logic                    rec_q, rec_d, jmp_q, jmp_d, zc_q, zc_d;
  logic                    sgn_q, sgn_d;

  logic                    ov_q, ov_d;
  logic signed [SPD_W-1:0] oref_q, oref_d, oint_q, oint_d;
  logic                    orel_q, orel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      filt_q  <= '0;
      ref_q   <= '0;
      int_q   <= '0;
      rel_q   <= 1'b0;
      el_q    <= '0;
      had_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      filt_q  <= filt_d;
      ref_q   <= ref_d;
      int_q   <= int_d;
      rel_q   <= rel_d;
      el_q    <= el_d;
      had_q   <= had_d;
      ov_q    <= ov_d;
    end
  end

  // Per-tick operands and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    meas_q <= meas_d;
    js_q   <= js_d;
    dt_q   <= dt_d;
    rec_q  <= rec_d;
    jmp_q  <= jmp_d;
    zc_q   <= zc_d;
    sgn_q  <= sgn_d;
    oref_q <= oref_d;
    oint_q <= oint_d;
    orel_q <= orel_d;
  end

  always_comb begin
    logic signed [SPD_W:0]     diff;
    logic [SPD_W:0]            dmag;
    logic signed [MUL_P_W:0]   sprod;
    logic signed [MUL_P_W:0]   rnd;
    logic signed [26:0]        fsum;
    logic signed [SPD_W-1:0]   fnew, tgt;
    logic                      rel;
    logic [TMO_W:0]            esum;
    logic [TMO_W-1:0]          el;
    logic [LIM_W-1:0]          rate;
    logic [MS_W-1:0]           ms;
    logic signed [SPD_W:0]     delta, msp;
    logic signed [SPD_W-1:0]   rnew;
    logic signed [DIV_N_W-1:0] y;
    logic signed [SPD_W:0]     qs, iacc, ilp;

    state_d   = state_q;
    filt_d    = filt_q;
    ref_d     = ref_q;
    int_d     = int_q;
    rel_d     = rel_q;
    el_d      = el_q;
    had_d     = had_q;
    tgt_d     = tgt_q;
    meas_d    = meas_q;
    js_d      = js_q;
    dt_d      = dt_q;
    rec_d     = rec_q;
    jmp_d     = jmp_q;
    zc_d      = zc_q;
    sgn_d     = sgn_q;
    oref_d    = oref_q;
    oint_d    = oint_q;
    orel_d    = orel_q;
    ov_d      = ov_q && !out_o.ready;
    in_i.ready = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;

    diff  = '0;
    dmag  = '0;
    sprod = '0;
    rnd   = '0;
    fsum  = '0;
    fnew  = '0;
    tgt   = '0;
    rel   = 1'b0;
    esum  = '0;
    el    = '0;
    rate  = '0;
    ms    = '0;
    delta = '0;
    msp   = '0;
    rnew  = '0;
    y     = '0;
    qs    = '0;
    iacc  = '0;
    ilp   = '0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          dt_d   = in_i.step_time_us;
          meas_d = in_i.measured_speed;
          js_d   = in_i.jump_speed;
          rec_d  = in_i.recover_mode;
          jmp_d  = in_i.jump_mode;
          zc_d   = abs24(in_i.command_speed) < {1'b0, dz_q};
          // Filter update: (command - filtered) * alpha, sign and magnitude.
          diff   = {in_i.command_speed[SPD_W-1], in_i.command_speed}
                 - {filt_q[SPD_W-1], filt_q};
          dmag   = diff[SPD_W] ? -diff : diff;
          sgn_d  = diff[SPD_W];
          mul_a  = dmag[SPD_W-1:0];
          mul_b  = alpha_eff;
          mul_start = 1'b1;
          state_d = S_FILT;
        end
      end

      S_FILT: begin
        if (mul_done) begin
          sprod = sgn_q ? -{1'b0, mul_p} : {1'b0, mul_p};
          rnd   = sprod + (MUL_P_W+1)'(32768);
          fsum  = 27'(filt_q) + 27'($signed(rnd[MUL_P_W:16]));
          fnew  = sat24(fsum);
          if (rec_q) begin
            filt_d = '0;
            ref_d  = '0;
            int_d  = '0;
            rel_d  = 1'b0;
            el_d   = '0;
            had_d  = 1'b0;
            state_d = S_OUT;
          end else if (jmp_q) begin
            filt_d = '0;
            ref_d  = js_q;
            rel_d  = 1'b0;
            el_d   = '0;
            had_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            rel = rel_q;
            el  = el_q;
            // Leaving the dead zone cancels a window; entering it after a
            // command opens a fresh one and drops the filter history.
            if (!zc_q) begin
              rel = 1'b0;
              el  = '0;
            end else if (had_q) begin
              rel  = 1'b1;
              el   = '0;
              fnew = '0;
            end
            tgt = (abs24(fnew) < {1'b0, dz_q}) ? '0 : fnew;
            if (rel) begin
              esum = {1'b0, el} + (TMO_W+1)'(dt_q);
              el   = esum[TMO_W] ? '1 : esum[TMO_W-1:0];
              tgt  = '0;
              // The window closes once the wheels have stopped or it timed out.
              if (abs24(meas_q) < {1'b0, stop_q} || el >= tmo_q) begin
                rel = 1'b0;
                el  = '0;
              end
            end
            if (rel) rate = rdec_q;
            else if (abs24(tgt) > abs24(ref_q)) rate = acc_lim_q;
            else rate = dec_lim_q;
            filt_d = fnew;
            rel_d  = rel;
            el_d   = el;
            had_d  = !zc_q;
            tgt_d  = tgt;
            mul_a  = MUL_A_W'(rate);
            mul_b  = MUL_B_W'(dt_q);
            mul_start = 1'b1;
            state_d = S_RMUL;
          end
        end
      end

      S_RMUL: begin
        if (mul_done) begin
          div_n     = DIV_N_W'(mul_p) + DIV_N_W'(HALF_S);
          div_start = 1'b1;
          state_d   = S_RDIV;
        end
      end

      S_RDIV: begin
        if (div_done) begin
          ms    = div_q[MS_W-1:0];
          msp   = (SPD_W+1)'(ms);
          delta = {tgt_q[SPD_W-1], tgt_q} - {ref_q[SPD_W-1], ref_q};
          if (delta > msp) delta = msp;
          if (delta < -msp) delta = -msp;
          rnew = sat24(27'(ref_q) + 27'(delta));
          // Near zero the reference snaps to rest instead of dithering.
          if (abs24(tgt_q) < {1'b0, dz_q} && abs24(rnew) < SPD_W'(ms)) rnew = '0;
          ref_d = rnew;
          if (rel_q) begin
            state_d = S_OUT;
          end else begin
            diff  = {rnew[SPD_W-1], rnew} - {meas_q[SPD_W-1], meas_q};
            dmag  = diff[SPD_W] ? -diff : diff;
            sgn_d = diff[SPD_W];
            mul_a = dmag[SPD_W-1:0];
            mul_b = MUL_B_W'(dt_q);
            mul_start = 1'b1;
            state_d = S_IMUL;
          end
        end
      end

      S_IMUL: begin
        if (mul_done) begin
          sprod = sgn_q ? -{1'b0, mul_p} : {1'b0, mul_p};
          y     = DIV_N_W'(sprod) + DIV_N_W'(HALF_S);
          // Floor division of a negative value: divide the magnitude rounded up.
          sgn_d = y[DIV_N_W-1];
          div_n = y[DIV_N_W-1] ? (-y + DIV_N_W'(US_PER_S - 1)) : y;
          div_start = 1'b1;
          state_d = S_IDIV;
        end
      end

      S_IDIV: begin
        if (div_done) begin
          qs   = (SPD_W+1)'(div_q[21:0]);
          if (sgn_q) qs = -qs;
          iacc = {int_q[SPD_W-1], int_q} + qs;
          ilp  = (SPD_W+1)'(ilim_q);
          if (iacc > ilp) iacc = ilp;
          if (iacc < -ilp) iacc = -ilp;
          int_d   = iacc[SPD_W-1:0];
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          oref_d  = ref_q;
          oint_d  = int_q;
          orel_d  = rel_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_o.valid           = ov_q;
  assign out_o.reference_speed = oref_q;
  assign out_o.error_integral  = oint_q;
  assign out_o.releasing       = orel_q;

endmodule

// ===== bench/lvrs_tb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the velocity reference shaper bench: tick and result records.
// Depends on lvrs_pkg for field widths.
package lvrs_tb_pkg;
  import lvrs_pkg::*;

  typedef struct {
    logic [DT_W-1:0]         dt;
    logic signed [SPD_W-1:0] cmd;
    logic signed [SPD_W-1:0] meas;
    logic                    recover;
    logic                    jump;
    logic signed [SPD_W-1:0] jspeed;
  } tick_t;

  typedef struct {
    logic signed [SPD_W-1:0] ref_spd;
    logic signed [SPD_W-1:0] integ;
    logic                    rel;
  } shaped_t;
endpackage

// ===== bench/linear_velocity_reference_shaper_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for linear_velocity_reference_shaper_unit: random and
// directed ticks against a built-in shaper model. Depends on lvrs_pkg, lvrs_tb_pkg, lvrs_intf and the unit.
module linear_velocity_reference_shaper_unit_tb;
  import lvrs_pkg::*;
  import lvrs_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  lvrs_in_if  tick_ch ();
  lvrs_out_if res_ch ();

  linear_velocity_reference_shaper_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(tick_ch.sink), .out_o(res_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model copy of the tuning registers and the shaper state.
  longint tune [8];
  longint filt_cmd, ref_val, integ_val, rel_elapsed;
  bit rel_open, had_cmd;

  shaped_t expected_q[$];
  int n_bad = 0;
  int n_checked = 0;
  int n_sent = 0;
  int hold_off = 0;     // long receiver stall, counted in the receiver process
  bit rx_idle_en = 1'b1;

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clip24(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic longint fdiv(longint x, longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic void reset_shaper();
    tune[REG_DEAD_ZONE] = 1311;       tune[REG_FILTER_ALPHA] = 2674;
    tune[REG_ACCEL_LIMIT] = 104858;   tune[REG_DECEL_LIMIT] = 203162;
    tune[REG_REL_DECEL] = 471859;     tune[REG_REL_TIMEOUT] = 450000;
    tune[REG_STOP_SPEED] = 2294;      tune[REG_INT_LIMIT] = 65536;
    filt_cmd = 0; ref_val = 0; integ_val = 0;
    rel_open = 0; rel_elapsed = 0; had_cmd = 0;
  endfunction

  // Advances the shaper by one tick and returns the result it produces.
  function automatic shaped_t shape_tick(tick_t t);
    shaped_t r;
    longint dt, cmd, meas, dz, alpha, tgt, delta, rate, step_lim, acc;
    bit cmd_idle, start_rel;
    dt = t.dt; cmd = t.cmd; meas = t.meas;
    dz = tune[REG_DEAD_ZONE];
    alpha = tune[REG_FILTER_ALPHA] > 65536 ? 65536 : tune[REG_FILTER_ALPHA];
    cmd_idle = mag(cmd) < dz;
    start_rel = cmd_idle && had_cmd;
    filt_cmd = clip24(filt_cmd + fdiv((cmd - filt_cmd) * alpha + 32768, 65536));
    if (t.recover) begin
      filt_cmd = 0; ref_val = 0; integ_val = 0;
      rel_open = 0; rel_elapsed = 0; had_cmd = 0;
    end else if (t.jump) begin
      filt_cmd = 0; ref_val = t.jspeed;
      rel_open = 0; rel_elapsed = 0; had_cmd = 0;
    end else begin
      if (!cmd_idle) begin
        rel_open = 0; rel_elapsed = 0;
      end else if (start_rel) begin
        rel_open = 1; rel_elapsed = 0; filt_cmd = 0;
      end
      tgt = (mag(filt_cmd) < dz) ? 0 : filt_cmd;
      if (rel_open) begin
        rel_elapsed = rel_elapsed + dt;
        if (rel_elapsed > 64'hFFFFFF) rel_elapsed = 64'hFFFFFF;
        tgt = 0;
        if (mag(meas) < tune[REG_STOP_SPEED] || rel_elapsed >= tune[REG_REL_TIMEOUT]) begin
          rel_open = 0; rel_elapsed = 0;
        end
      end
      delta = tgt - ref_val;
      rate = (mag(tgt) > mag(ref_val)) ? tune[REG_ACCEL_LIMIT] : tune[REG_DECEL_LIMIT];
      if (rel_open) rate = tune[REG_REL_DECEL];
      step_lim = (rate * dt + US_PER_S / 2) / US_PER_S;
      if (delta > step_lim) delta = step_lim;
      if (delta < -step_lim) delta = -step_lim;
      ref_val = clip24(ref_val + delta);
      if (mag(tgt) < dz && mag(ref_val) < step_lim) ref_val = 0;
      if (!rel_open) begin
        acc = integ_val + fdiv((ref_val - meas) * dt + US_PER_S / 2, US_PER_S);
        if (acc > tune[REG_INT_LIMIT]) acc = tune[REG_INT_LIMIT];
        if (acc < -tune[REG_INT_LIMIT]) acc = -tune[REG_INT_LIMIT];
        integ_val = acc;
      end
      had_cmd = !cmd_idle;
    end
    r.ref_spd = ref_val[SPD_W-1:0];
    r.integ = integ_val[SPD_W-1:0];
    r.rel = rel_open;
    return r;
  endfunction

  // Offers one request after a random gap, then holds it until accepted.
  // Valid stays high after acceptance until the next gap or the drain.
  task automatic send_tick(tick_t t);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.step_time_us <= t.dt;
    tick_ch.command_speed <= t.cmd;
    tick_ch.measured_speed <= t.meas;
    tick_ch.recover_mode <= t.recover;
    tick_ch.jump_mode <= t.jump;
    tick_ch.jump_speed <= t.jspeed;
    do @(posedge clk_i); while (!tick_ch.ready);
    expected_q.push_back(shape_tick(t));
    n_sent++;
  endtask

  // Drops valid and waits until every expected result has come, then idles before returning.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    tune[idx] = (idx == REG_FILTER_ALPHA) ? (val & 64'h1FFFF) :
                (idx == REG_REL_TIMEOUT) ? (val & 64'hFFFFFF) : (val & 64'h7FFFFF);
    cfg_we_i <= 1'b0;
  endtask

  function automatic tick_t make_tick(int dt, int cmd, int meas, bit rec, bit jmp, int js);
    tick_t t;
    t.dt = dt[DT_W-1:0]; t.cmd = cmd[SPD_W-1:0]; t.meas = meas[SPD_W-1:0];
    t.recover = rec; t.jump = jmp; t.jspeed = js[SPD_W-1:0];
    return t;
  endfunction

  function automatic int rand_s24();
    int v;
    v = $urandom();
    return {{8{v[23]}}, v[23:0]};
  endfunction

  // Random tick: mostly plausible drive sequences, with some full-range noise.
  function automatic tick_t random_tick();
    tick_t t;
    int sel;
    sel = $urandom_range(0, 99);
    t = make_tick($urandom_range(500, 5000), $urandom_range(0, 1) ? 0 : rand_s24() >>> 4,
                  rand_s24() >>> 6, 0, 0, 0);
    if ($urandom_range(0, 2) == 0) t.cmd = SPD_W'($urandom_range(0, 1500) - 750);
    if (sel < 3) t.recover = 1;
    else if (sel < 8) begin
      t.jump = 1; t.jspeed = SPD_W'(rand_s24());
    end else if (sel < 20) begin
      t.dt = DT_W'($urandom()); t.cmd = SPD_W'(rand_s24()); t.meas = SPD_W'(rand_s24());
      t.jspeed = SPD_W'(rand_s24()); t.recover = $urandom_range(0, 7) == 0;
    end
    return t;
  endfunction

  task automatic test_directed();
    send_tick(make_tick(1000, 65536, 0, 0, 0, 0));
    send_tick(make_tick(65535, 8388607, -8388608, 0, 0, 0));
    send_tick(make_tick(65535, -8388608, 8388607, 0, 0, 0));
    send_tick(make_tick(0, 8388607, 0, 0, 0, 0));
    // Release start: command drops into the dead zone after a large one.
    send_tick(make_tick(1000, 0, 65536, 0, 0, 0));
    send_tick(make_tick(65535, 0, 65536, 0, 0, 0));
    send_tick(make_tick(1000, 0, 0, 0, 0, 0));
    send_tick(make_tick(1000, 100000, 0, 0, 1, -8388608));
    send_tick(make_tick(1000, 100000, 0, 0, 1, 8388607));
    send_tick(make_tick(2000, 200000, 0, 0, 0, 0));
    send_tick(make_tick(1000, 0, 0, 1, 1, 8388607));
    send_tick(make_tick(1000, -300000, 100, 0, 0, 0));
    send_tick(make_tick(1000, 5, 8388607, 0, 0, 0));
    send_tick(make_tick(1000, -5, -8388608, 0, 0, -1));
    drain();
  endtask

  // Long release window with the timer saturating at its top.
  task automatic test_release_window();
    int i;
    write_reg(REG_REL_TIMEOUT, 24'hFFFFFF);
    write_reg(REG_STOP_SPEED, 0);
    write_reg(REG_REL_DECEL, 8388607);
    send_tick(make_tick(1000, 500000, 0, 0, 0, 0));
    for (i = 0; i < 260; i++) send_tick(make_tick(65535, 0, 90000, 0, 0, 0));
    drain();
    // Zero timeout closes the window in its opening tick.
    write_reg(REG_REL_TIMEOUT, 0);
    send_tick(make_tick(1000, 500000, 0, 0, 0, 0));
    send_tick(make_tick(1000, 0, 90000, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_phase(int count);
    int i;
    for (i = 0; i < count; i++) send_tick(random_tick());
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DEAD_ZONE, 8388607);
    write_reg(REG_FILTER_ALPHA, 131071);
    write_reg(REG_ACCEL_LIMIT, 8388607);
    write_reg(REG_DECEL_LIMIT, 8388607);
    write_reg(REG_REL_DECEL, 8388607);
    write_reg(REG_REL_TIMEOUT, 16777215);
    write_reg(REG_STOP_SPEED, 8388607);
    write_reg(REG_INT_LIMIT, 8388607);
    test_random_phase(30);
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_FILTER_ALPHA, 0);
    write_reg(REG_ACCEL_LIMIT, 0);
    write_reg(REG_DECEL_LIMIT, 0);
    write_reg(REG_REL_DECEL, 0);
    write_reg(REG_STOP_SPEED, 0);
    write_reg(REG_INT_LIMIT, 0);
    test_random_phase(20);
  endtask

  task automatic test_random_settings();
    write_reg(REG_DEAD_ZONE, $urandom_range(0, 4000));
    write_reg(REG_FILTER_ALPHA, $urandom_range(0, 70000));
    write_reg(REG_ACCEL_LIMIT, $urandom_range(0, 8388607));
    write_reg(REG_DECEL_LIMIT, $urandom_range(0, 8388607));
    write_reg(REG_REL_DECEL, $urandom_range(0, 8388607));
    write_reg(REG_REL_TIMEOUT, $urandom_range(0, 20000));
    write_reg(REG_STOP_SPEED, $urandom_range(0, 5000));
    write_reg(REG_INT_LIMIT, $urandom_range(0, 8388607));
    test_random_phase(40);
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int i;
    hold_off = 600;
    for (i = 0; i < 6; i++) send_tick(random_tick());
    drain();
  endtask

  // Result checker: pops the oldest expectation for every accepted result.
  always @(posedge clk_i) begin
    shaped_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result ref=%0d int=%0d",
                                  res_ch.reference_speed, res_ch.error_integral);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.ref_spd !== res_ch.reference_speed || e.integ !== res_ch.error_integral ||
            e.rel !== res_ch.releasing) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected ref=%0d int=%0d rel=%0b, got ref=%0d int=%0d rel=%0b",
                     e.ref_spd, e.integ, e.rel, res_ch.reference_speed,
                     res_ch.error_integral, res_ch.releasing);
        end
      end
    end
  end

  // Receiver: random stalls per result, plus an occasional long hold-off.
  initial begin
    int wait_n;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      wait_n = rx_idle_en ? $urandom_range(0, 11) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  initial begin
    #60ms;
    $display("linear_velocity_reference_shaper_unit regression: fail");
    $finish;
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.step_time_us = '0;
    tick_ch.command_speed = '0;
    tick_ch.measured_speed = '0;
    tick_ch.recover_mode = 1'b0;
    tick_ch.jump_mode = 1'b0;
    tick_ch.jump_speed = '0;
    reset_shaper();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_release_window();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    reset_shaper();
    // Back to the reset tuning, written explicitly, for a final default run.
    write_reg(REG_DEAD_ZONE, 1311);   write_reg(REG_FILTER_ALPHA, 2674);
    write_reg(REG_ACCEL_LIMIT, 104858); write_reg(REG_DECEL_LIMIT, 203162);
    write_reg(REG_REL_DECEL, 471859); write_reg(REG_REL_TIMEOUT, 450000);
    write_reg(REG_STOP_SPEED, 2294);  write_reg(REG_INT_LIMIT, 65536);
    send_tick(make_tick(1000, 0, 0, 1, 0, 0));
    test_random_phase(30);
    $display("Sent %0d ticks over directed, release, extreme, random and stall phases;",
             n_sent);
    $display("checked %0d results, %0d mismatches.", n_checked, n_bad);
    if (n_bad == 0 && expected_q.size() == 0) begin
      $display("linear_velocity_reference_shaper_unit regression: pass");
    end else begin
      $display("linear_velocity_reference_shaper_unit regression: fail");
    end
    $finish;
  end
endmodule
